// ===== sv/mp4acw_pkg.sv =====
// Shared types, constants and a helper function of the MP4 atom chain walker.
package mp4acw_pkg;

  localparam int unsigned OffsetW   = 47;
  localparam int unsigned ExpectedW = 63;
  localparam int unsigned PosW      = 64;
  localparam int unsigned CountW    = 5;
  localparam int unsigned HdrBytes  = 16;
  localparam int unsigned NumTypes  = 19;

  localparam logic [CountW-1:0] ShortHdrLen = CountW'(8);
  localparam logic [CountW-1:0] LongHdrLen  = CountW'(16);
  localparam logic [31:0]       ExtSizeMark = 32'd1;
  localparam logic [PosW-1:0]   MinSize32   = PosW'(8);
  localparam logic [PosW-1:0]   MinSize64   = PosW'(16);

  typedef enum logic [1:0] {
    StopNone  = 2'd0,
    StopSmall = 2'd1,
    StopLarge = 2'd2,
    StopType  = 2'd3
  } stop_reason_e;

  // Atom types that keep the walk going.
  localparam logic [31:0] KnownTypes [NumTypes] = '{
    32'h6d646174, 32'h636d6f76, 32'h636d7664, 32'h64636f6d, 32'h66726561,
    32'h66726565, 32'h66747970, 32'h6a703268, 32'h6d646961, 32'h6d657461,
    32'h6d6f6f76, 32'h50494354, 32'h706e6f74, 32'h736b6970, 32'h7374626c,
    32'h7468756d, 32'h7472616b, 32'h75756964, 32'h77696465
  };

  typedef struct packed {
    logic                 ok;
    stop_reason_e         code;
    logic [ExpectedW-1:0] next_offset;
  } judge_t;

  typedef struct packed {
    logic                 verdict;
    stop_reason_e         stop_reason;
    logic [ExpectedW-1:0] expected_size;
    logic                 atom_accepted;
  } walk_result_t;

  function automatic logic type_known(input logic [31:0] fourcc);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumTypes; k++) begin
      if (KnownTypes[k] == fourcc) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== sv/mp4acw_if.sv =====
// Handshake channels for file bytes in and walk results out.
interface mp4acw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_file;

  modport source (output valid, output data_byte, output new_file, input ready);
  modport sink (input valid, input data_byte, input new_file, output ready);
endinterface

interface mp4acw_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [1:0]  stop_reason;
  logic [62:0] expected_size;
  logic        atom_accepted;

  modport source (output valid, output verdict, output stop_reason,
                  output expected_size, output atom_accepted, input ready);
  modport sink (input valid, input verdict, input stop_reason,
                input expected_size, input atom_accepted, output ready);
endinterface

// ===== sv/mp4acw_judge.sv =====
// Header check: size bounds, type lookup and the saturating advance of the next offset.
module mp4acw_judge import mp4acw_pkg::*; (
  input  logic [PosW-1:0]      size_i,
  input  logic [31:0]          fourcc_i,
  input  logic                 ext_i,
  input  logic [ExpectedW-1:0] next_offset_i,
  output judge_t               judge_o
);

  logic [PosW-1:0] min_size;
  logic [PosW-1:0] sum;
  logic            too_small;
  logic            too_large;

  assign min_size  = ext_i ? MinSize64 : MinSize32;
  assign too_small = size_i < min_size;
  assign too_large = |size_i[PosW-1:OffsetW];
  // The offset is below 2^63, so a set top bit of the sum means saturation.
  assign sum       = {1'b0, next_offset_i} + size_i;

  always_comb begin
    judge_o.ok          = 1'b0;
    judge_o.code        = StopNone;
    judge_o.next_offset = sum[PosW-1] ? {ExpectedW{1'b1}} : sum[ExpectedW-1:0];
    if (too_small) begin
      judge_o.code = StopSmall;
    end else if (too_large) begin
      judge_o.code = StopLarge;
    end else if (!type_known(fourcc_i)) begin
      judge_o.code = StopType;
    end else begin
      judge_o.ok = 1'b1;
    end
  end

endmodule

// ===== sv/mp4acw_core.sv =====
// Walk state: byte position, next header offset, header bytes and the sticky stop.
module mp4acw_core import mp4acw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         data_byte_i,
  input  logic               new_file_i,
  input  logic [OffsetW-1:0] first_offset_i,
  output walk_result_t       result_o
);

  logic [PosW-1:0]      pos_q, pos_d, pos_cur;
  logic [ExpectedW-1:0] next_q, next_d, next_cur;
  logic [CountW-1:0]    cnt_q, cnt_d, cnt_cur, cnt_inc;
  logic                 stop_q, stop_d, stop_cur;
  stop_reason_e         code_q, code_d, code_cur;
  // The last header byte is always the current one, so it is never stored.
  logic [7:0]           hdr_q [HdrBytes-1];

  logic            capture;
  logic            is_ext;
  logic            do_judge;
  logic [31:0]     size32;
  logic [31:0]     fourcc;
  logic [PosW-1:0] size;
  judge_t          judge;
  logic            accepted;

  // A new file clears the walk before its first byte is looked at.
  assign pos_cur  = new_file_i ? '0 : pos_q;
  assign next_cur = new_file_i ? {{(ExpectedW-OffsetW){1'b0}}, first_offset_i} : next_q;
  assign cnt_cur  = new_file_i ? '0 : cnt_q;
  assign stop_cur = new_file_i ? 1'b0 : stop_q;
  assign code_cur = new_file_i ? StopNone : code_q;

  assign capture = !stop_cur && ((cnt_cur != '0) || (pos_cur == {1'b0, next_cur}));
  assign cnt_inc = cnt_cur + CountW'(1);
  assign is_ext  = (cnt_inc == LongHdrLen);
  assign size32  = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
  assign fourcc  = is_ext ? {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]}
                          : {hdr_q[4], hdr_q[5], hdr_q[6], data_byte_i};
  assign size    = is_ext ? {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11],
                             hdr_q[12], hdr_q[13], hdr_q[14], data_byte_i}
                          : {32'b0, size32};
  assign do_judge = capture &&
                    (is_ext || ((cnt_inc == ShortHdrLen) && (size32 != ExtSizeMark)));

  mp4acw_judge u_judge (
    .size_i        (size),
    .fourcc_i      (fourcc),
    .ext_i         (is_ext),
    .next_offset_i (next_cur),
    .judge_o       (judge)
  );

  always_comb begin
    pos_d    = pos_cur + PosW'(1);
    next_d   = next_cur;
    cnt_d    = capture ? cnt_inc : cnt_cur;
    stop_d   = stop_cur;
    code_d   = code_cur;
    accepted = 1'b0;
    if (do_judge) begin
      cnt_d = '0;
      if (judge.ok) begin
        next_d   = judge.next_offset;
        accepted = 1'b1;
      end else begin
        stop_d = 1'b1;
        code_d = judge.code;
      end
    end
  end

  assign result_o.verdict       = stop_d;
  assign result_o.stop_reason   = code_d;
  assign result_o.expected_size = next_d;
  assign result_o.atom_accepted = accepted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      next_q <= '0;
      cnt_q  <= '0;
      stop_q <= 1'b0;
      code_q <= StopNone;
    end else if (fire_i) begin
      pos_q  <= pos_d;
      next_q <= next_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
      code_q <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && capture && (cnt_cur[3:0] != 4'(HdrBytes-1))) begin
      hdr_q[cnt_cur[3:0]] <= data_byte_i;
    end
  end

endmodule

// ===== sv/mp4_atom_chain_walker.sv =====
// Top level of the MP4 atom chain walker: input register, walk core and result register.
// The walker takes one file byte per clock while the sink keeps up and returns one result
// item per byte: the byte is held in an input register, the walk state and header check
// are updated in a single pass, and the result goes to an output register that may wait
// for the sink while one more byte is taken. A byte with new_file set starts a new file;
// the cfg_data_i offset is loaded at each new file, so a write to it affects the next
// file, and the walk starts at offset zero after reset. The stop is sticky until new_file.
module mp4_atom_chain_walker import mp4acw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [OffsetW-1:0] cfg_data_i,
  mp4acw_in_if.sink          in_i,
  mp4acw_out_if.source       out_o
);

  logic [OffsetW-1:0] first_q;
  logic               s1_valid_q;
  logic [7:0]         s1_byte_q;
  logic               s1_new_q;
  logic               out_valid_q;
  walk_result_t       out_q;
  walk_result_t       result;
  logic               advance;
  logic               fire;

  assign advance  = !out_valid_q || out_o.ready;
  assign fire     = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
    end else if (cfg_we_i) begin
      first_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_new_q  <= in_i.new_file;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  mp4acw_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .data_byte_i    (s1_byte_q),
    .new_file_i     (s1_new_q),
    .first_offset_i (first_q),
    .result_o       (result)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.verdict       = out_q.verdict;
  assign out_o.stop_reason   = out_q.stop_reason;
  assign out_o.expected_size = out_q.expected_size;
  assign out_o.atom_accepted = out_q.atom_accepted;

endmodule

// ===== dv/tb_mp4_atom_chain_walker.sv =====
// Self-checking testbench for the MP4 atom chain walker: scripted and random byte streams.
`timescale 1ns / 1ps
module tb_mp4_atom_chain_walker;
  import mp4acw_pkg::*;

  localparam int unsigned          StallLimit = 3000;
  localparam logic [63:0]          SizeLimit  = 64'd1 << OffsetW;
  localparam logic [63:0]          MaxAtom    = SizeLimit - 64'd1;
  localparam logic [OffsetW-1:0]   MaxOffset  = '1;
  localparam logic [ExpectedW-1:0] MaxEnd     = '1;
  localparam walk_result_t         FreshFile  = '{1'b0, StopNone, 63'd0, 1'b0};
  localparam walk_result_t         Unchecked  = '0;

  typedef struct {
    logic [7:0]   data_byte;
    logic         new_file;
    logic         typed;
    walk_result_t want;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [OffsetW-1:0] cfg_data_i;

  mp4acw_in_if  in_if ();
  mp4acw_out_if out_if ();

  mp4_atom_chain_walker dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Walk state as the predictor sees it.
  logic [OffsetW-1:0]   walk_first;
  logic [63:0]          walk_pos;
  logic [ExpectedW-1:0] walk_next;
  logic [7:0]           walk_hdr [HdrBytes];
  logic [CountW-1:0]    walk_count;
  logic                 walk_halted;
  stop_reason_e         walk_code;

  walk_result_t results_due [$];
  logic [7:0]   file_bytes [$];
  logic         script_check;
  walk_result_t script_want;
  int           n_in;
  int           n_sent;
  int           n_fail;
  bit           quiet_in;
  bit           quiet_out;

  // Opening of the stream: a minimal mdat atom, then an extended header whose 64-bit size
  // is all ones, then a new file that clears the stop.
  script_row_t walk_script [25] = '{
    '{8'h00, 1'b0, 1'b1, FreshFile}, '{8'h00, 1'b0, 1'b0, Unchecked},
    '{8'h00, 1'b0, 1'b0, Unchecked}, '{8'h08, 1'b0, 1'b0, Unchecked},
    '{8'h6d, 1'b0, 1'b0, Unchecked}, '{8'h64, 1'b0, 1'b0, Unchecked},
    '{8'h61, 1'b0, 1'b0, Unchecked},
    '{8'h74, 1'b0, 1'b1, '{1'b0, StopNone, 63'd8, 1'b1}},
    '{8'h00, 1'b0, 1'b0, Unchecked}, '{8'h00, 1'b0, 1'b0, Unchecked},
    '{8'h00, 1'b0, 1'b0, Unchecked}, '{8'h01, 1'b0, 1'b0, Unchecked},
    '{8'h50, 1'b0, 1'b0, Unchecked}, '{8'h49, 1'b0, 1'b0, Unchecked},
    '{8'h43, 1'b0, 1'b0, Unchecked}, '{8'h54, 1'b0, 1'b0, Unchecked},
    '{8'hff, 1'b0, 1'b0, Unchecked}, '{8'hff, 1'b0, 1'b0, Unchecked},
    '{8'hff, 1'b0, 1'b0, Unchecked}, '{8'hff, 1'b0, 1'b0, Unchecked},
    '{8'hff, 1'b0, 1'b0, Unchecked}, '{8'hff, 1'b0, 1'b0, Unchecked},
    '{8'hff, 1'b0, 1'b0, Unchecked},
    '{8'hff, 1'b0, 1'b1, '{1'b1, StopLarge, 63'd8, 1'b0}},
    '{8'h00, 1'b1, 1'b1, FreshFile}
  };

  function automatic logic fourcc_known(input logic [31:0] t);
    case (t)
      "mdat", "cmov", "cmvd", "dcom", "frea", "free", "ftyp", "jp2h", "mdia", "meta",
      "moov", "PICT", "pnot", "skip", "stbl", "thum", "trak", "uuid", "wide": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void restart_walk();
    walk_pos    = '0;
    walk_next   = ExpectedW'(walk_first);
    walk_count  = '0;
    walk_halted = 1'b0;
    walk_code   = StopNone;
  endfunction

  function automatic walk_result_t predict_byte(input logic [7:0] b, input logic nf);
    logic        took;
    logic        judge;
    logic [63:0] size;
    logic [63:0] floor_sz;
    logic [31:0] fourcc;
    took     = 1'b0;
    judge    = 1'b0;
    size     = '0;
    floor_sz = '0;
    if (nf) restart_walk();
    if (!walk_halted && (walk_count != 0 || walk_pos == {1'b0, walk_next})) begin
      walk_hdr[walk_count[3:0]] = b;
      walk_count = walk_count + 1'b1;
      if (walk_count == ShortHdrLen &&
          {walk_hdr[0], walk_hdr[1], walk_hdr[2], walk_hdr[3]} != ExtSizeMark) begin
        judge    = 1'b1;
        size     = {32'd0, walk_hdr[0], walk_hdr[1], walk_hdr[2], walk_hdr[3]};
        floor_sz = MinSize32;
      end else if (walk_count == LongHdrLen) begin
        judge    = 1'b1;
        size     = {walk_hdr[8], walk_hdr[9], walk_hdr[10], walk_hdr[11],
                    walk_hdr[12], walk_hdr[13], walk_hdr[14], walk_hdr[15]};
        floor_sz = MinSize64;
      end
      if (judge) begin
        fourcc     = {walk_hdr[4], walk_hdr[5], walk_hdr[6], walk_hdr[7]};
        walk_count = '0;
        if (size < floor_sz) begin
          walk_halted = 1'b1;
          walk_code   = StopSmall;
        end else if (size >= SizeLimit) begin
          walk_halted = 1'b1;
          walk_code   = StopLarge;
        end else if (!fourcc_known(fourcc)) begin
          walk_halted = 1'b1;
          walk_code   = StopType;
        end else begin
          took = 1'b1;
          if (walk_next > MaxEnd - size[ExpectedW-1:0]) walk_next = MaxEnd;
          else walk_next = walk_next + size[ExpectedW-1:0];
        end
      end
    end
    walk_pos = walk_pos + 64'd1;
    return '{walk_halted, walk_code, walk_next, took};
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void put_be(input logic [63:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) file_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_fill(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  // One file: filler to the first header if within 40 bytes, then a chain of atoms with random
  // bodies. A bad header ends the chain, followed by a few bytes the stopped walk must hold on.
  function automatic void build_file();
    int          lead;
    int          atoms;
    int          roll;
    int          sz;
    logic [31:0] kind;
    logic [63:0] big;
    bit          done;
    file_bytes.delete();
    lead = (walk_first > 40) ? $urandom_range(1, 40) : int'(walk_first);
    put_fill(lead);
    atoms = $urandom_range(1, 6);
    done  = 1'b0;
    for (int a = 0; a < atoms && !done; a++) begin
      kind = KnownTypes[$urandom_range(0, NumTypes - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 62) begin
        sz = $urandom_range(8, 40);
        put_be(sz, 4);
        put_be(kind, 4);
        put_fill(sz - 8);
      end else if (roll < 78) begin
        sz = $urandom_range(16, 48);
        put_be(ExtSizeMark, 4);
        put_be(kind, 4);
        put_be(sz, 8);
        put_fill(sz - 16);
      end else if (roll < 83) begin
        // Largest legal sizes: the rest of the file lies inside this atom.
        if ($urandom_range(0, 1)) begin
          put_be(32'hffff_ffff, 4);
          put_be(kind, 4);
        end else begin
          put_be(ExtSizeMark, 4);
          put_be(kind, 4);
          put_be(MaxAtom, 8);
        end
        put_fill($urandom_range(0, 10));
        done = 1'b1;
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            sz = $urandom_range(0, 6);
            if (sz != 0) sz++;  // a size field of one would select the extended form
            put_be(sz, 4);
            put_be(kind, 4);
          end
          1: begin
            put_be(ExtSizeMark, 4);
            put_be(kind, 4);
            put_be($urandom_range(0, 15), 8);
          end
          2: begin
            big = {$urandom, $urandom};
            big[$urandom_range(OffsetW, 63)] = 1'b1;
            if ($urandom_range(0, 3) == 0) big = SizeLimit;
            put_be(ExtSizeMark, 4);
            put_be(kind, 4);
            put_be(big, 8);
          end
          3: begin
            put_be($urandom_range(8, 40), 4);
            put_be($urandom, 4);
          end
          default: begin
            put_be($urandom_range(8, 40), 4);
            put_be(kind ^ (32'd1 << $urandom_range(0, 31)), 4);
          end
        endcase
        put_fill($urandom_range(0, 12));
        done = 1'b1;
      end
    end
    // Now and then the next file starts in the middle of this one.
    if ($urandom_range(0, 9) == 0) begin
      file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic nf, input logic typed = 1'b0,
                           input walk_result_t want = '0);
    int gap;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.new_file  <= nf;
    script_check    <= typed;
    script_want     <= want;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
    gap = quiet_in ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic play_file();
    int n;
    quiet_in = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 11) == 0) begin
      n = $urandom_range(4, 30);
      repeat (n) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    end else begin
      build_file();
      foreach (file_bytes[k]) send_byte(file_bytes[k], k == 0);
    end
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    walk_result_t predicted;
    if (in_if.valid && in_if.ready) begin
      n_in++;
      predicted = predict_byte(in_if.data_byte, in_if.new_file);
      results_due.push_back(script_check ? script_want : predicted);
    end
  end

  always @(posedge clk_i) begin
    walk_result_t want;
    if (out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $error("result item arrived with nothing expected");
        n_fail++;
      end else begin
        want = results_due.pop_front();
        if (out_if.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_if.verdict);
          n_fail++;
        end
        if (out_if.stop_reason !== want.stop_reason) begin
          $error("stop_reason: expected %0d, got %0d", want.stop_reason, out_if.stop_reason);
          n_fail++;
        end
        if (out_if.expected_size !== want.expected_size) begin
          $error("expected_size: expected %0h, got %0h", want.expected_size,
                 out_if.expected_size);
          n_fail++;
        end
        if (out_if.atom_accepted !== want.atom_accepted) begin
          $error("atom_accepted: expected %0d, got %0d", want.atom_accepted,
                 out_if.atom_accepted);
          n_fail++;
        end
      end
    end
  end

  initial begin
    int  lull;
    bit  squeezed;
    out_if.ready = 1'b0;
    squeezed     = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) quiet_out = !quiet_out;
      if (!squeezed && n_in >= 400 && in_if.valid) begin
        // Hold results back long enough for the walker to fill up and stall its input.
        squeezed = 1'b1;
        out_if.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end
      lull = quiet_out ? 0 : idle_len();
      if (lull > 0) begin
        out_if.ready <= 1'b0;
        repeat (lull) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [OffsetW-1:0] phase_cfg [5];
    int                 phase_len [5];
    int                 phase_start;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.new_file  = 1'b0;
    script_check    = 1'b0;
    script_want     = '0;
    n_in            = 0;
    n_sent          = 0;
    n_fail          = 0;
    quiet_in        = 1'b0;
    quiet_out       = 1'b0;
    walk_first      = '0;
    restart_walk();
    phase_cfg = '{47'd3, MaxOffset, 47'd0, 47'($urandom_range(1, 33)), 47'd17};
    phase_len = '{140, 30, 140, 140, 140};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (walk_script[r]) begin
      send_byte(walk_script[r].data_byte, walk_script[r].new_file, walk_script[r].typed,
                walk_script[r].want);
    end

    for (int p = 0; p < 5; p++) begin
      settle();
      cfg_we_i   <= 1'b1;
      cfg_data_i <= phase_cfg[p];
      @(posedge clk_i);
      cfg_we_i   <= 1'b0;
      walk_first = phase_cfg[p];
      // The old file goes on for a few bytes: the new offset only applies from the next file.
      repeat (3) send_byte(8'($urandom), 1'b0);
      phase_start = n_sent;
      while (n_sent - phase_start < phase_len[p]) play_file();
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
